### src/btc_pkg.sv
// ============================================================================
// btc_pkg: shared types and constants for the bitmask tour cost block
// Widths of the transaction fields, default sizes and the result status codes.
// ============================================================================
package btc_pkg;

  // Default sizing
  localparam int unsigned MAX_POINTS_DEF = 16;
  localparam int unsigned COORD_BITS_DEF = 8;

  // Fixed field widths
  localparam int unsigned COORD_W  = 8;
  localparam int unsigned COST_W   = 12;
  localparam int unsigned STATUS_W = 2;

  // Saturation ceiling for every cost sum
  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TOO_MANY  = 2'd1,
    STATUS_START_BAD = 2'd2
  } status_e;

endpackage

### src/btc_if.sv
// ============================================================================
// btc_if: valid/ready channels of the bitmask tour cost block
// Point channel into the block and result channel out of it.
// ============================================================================
interface btc_in_if
  import btc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] col;
  logic               is_start;
  logic               last;

  modport source (output valid, row, col, is_start, last, input ready);
  modport sink   (input valid, row, col, is_start, last, output ready);
endinterface

interface btc_out_if
  import btc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [COST_W-1:0]   tour_cost;
  logic [STATUS_W-1:0] status;

  modport source (output valid, tour_cost, status, input ready);
  modport sink   (input valid, tour_cost, status, output ready);
endinterface

### src/bitmask_tour_cost.sv
// Points are taken only in ST_LOAD while the result register is empty or being read.
// A set with a fault or only the start gives its result in the cycle after its last point.
// Otherwise, with n points, each (mask, j) with j in mask passes ST_JSEL, one table and
//   point read per k in ST_ISSUE (one read when only the start precedes j), the drain
//   through ST_WAIT1 and ST_WAIT2 and the write-back in ST_COMMIT; a j not in mask passes
//   ST_JSEL alone; this runs over 2^(n-1) - 1 masks, then the closing pass; the table memory port sets this pace.
// Reset: asynchronous, clears control and flags; point and table memories are not cleared.
// ============================================================================
// bitmask_tour_cost: closed tour cost over grid points (Held-Karp)
// Loads a start and targets, then walks the bitmask cost table in a memory
// with a read-modify-write loop and reports the least closed tour cost.
// ============================================================================
module bitmask_tour_cost
  import btc_pkg::*;
#(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  btc_in_if.sink     in_i,
  btc_out_if.source  out_o
);

  // Derived sizes
  localparam int unsigned CW     = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
  localparam int unsigned JW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned MW     = (MAX_POINTS > 1) ? MAX_POINTS - 1 : 1;
  localparam int unsigned TBL_AW = MW + JW;

  typedef enum logic [5:0] {
    ST_LOAD   = 6'b000001,
    ST_JSEL   = 6'b000010,
    ST_ISSUE  = 6'b000100,
    ST_WAIT1  = 6'b001000,
    ST_WAIT2  = 6'b010000,
    ST_COMMIT = 6'b100000
  } state_e;

  // Control state
  state_e                st_q, st_d;
  logic [JW-1:0]         count_q, count_d;
  logic                  seen_q, seen_d;
  logic                  rep_q, rep_d;
  logic                  ovf_q, ovf_d;
  logic [MAX_POINTS-1:0] mask_q, mask_d;
  logic [MAX_POINTS-1:0] prev_q, prev_d;
  logic [JW-1:0]         j_q, j_d;
  logic [JW-1:0]         k_q, k_d;
  logic                  single_q, single_d;
  logic                  final_q, final_d;
  logic [COST_W-1:0]     best_q, best_d;
  logic                  s1_v_q, s1_v_d;
  logic                  s1_zero_q, s1_zero_d;
  logic                  s2_v_q;
  logic                  out_valid_q, out_valid_d;

  // Payload registers
  logic [COST_W-1:0]     s2_tbl_q, s2_dist_q;
  logic [COST_W-1:0]     out_cost_q, out_cost_d;
  status_e               out_status_q, out_status_d;

  // Memories
  logic [CW-1:0]         pt_row_mem [MAX_POINTS];
  logic [CW-1:0]         pt_col_mem [MAX_POINTS];
  logic [COST_W-1:0]     tbl_mem    [2**TBL_AW];
  logic [CW-1:0]         pa_row_q, pa_col_q, pb_row_q, pb_col_q;
  logic [COST_W-1:0]     tbl_rdata_q;

  logic                  pt_we;
  logic [JW-1:0]         pt_waddr;
  logic                  tbl_we;
  logic [TBL_AW-1:0]     tbl_waddr, tbl_raddr;

  logic                  in_acc, out_acc, out_load;
  logic [MAX_POINTS-1:0] full;
  logic [CW-1:0]         dr, dc, pt_dist;
  logic [COST_W:0]       sum;
  logic [COST_W-1:0]     sum_sat;

  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_valid_q && out_o.ready;

  assign in_i.ready      = (st_q == ST_LOAD) && (!out_valid_q || out_o.ready);
  assign out_o.valid     = out_valid_q;
  assign out_o.tour_cost = out_cost_q;
  assign out_o.status    = out_status_q;

  // Mask of all stored points
  always_comb begin
    for (int i = 0; i < MAX_POINTS; i++) begin
      full[i] = (i <= int'(count_q));
    end
  end

  // Memory addresses: mask bit 0 is always set, so it is left out
  assign tbl_raddr = {MW'(prev_q >> 1), k_q};
  assign tbl_waddr = {MW'(mask_q >> 1), j_q};

  // Stage 1: Chebyshev distance of the two read points
  always_comb begin
    dr      = (pa_row_q > pb_row_q) ? pa_row_q - pb_row_q : pb_row_q - pa_row_q;
    dc      = (pa_col_q > pb_col_q) ? pa_col_q - pb_col_q : pb_col_q - pa_col_q;
    pt_dist = (dr > dc) ? dr : dc;
  end

  // Stage 2: saturating path cost
  always_comb begin
    sum     = {1'b0, s2_tbl_q} + {1'b0, s2_dist_q};
    sum_sat = sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
  end

  // Main control
  always_comb begin
    st_d         = st_q;
    count_d      = count_q;
    seen_d       = seen_q;
    rep_d        = rep_q;
    ovf_d        = ovf_q;
    mask_d       = mask_q;
    prev_d       = prev_q;
    j_d          = j_q;
    k_d          = k_q;
    single_d     = single_q;
    final_d      = final_q;
    best_d       = best_q;
    s1_v_d       = 1'b0;
    s1_zero_d    = single_q;
    out_load     = 1'b0;
    out_cost_d   = '0;
    out_status_d = STATUS_OK;
    pt_we        = 1'b0;
    pt_waddr     = '0;
    tbl_we       = 1'b0;

    // running minimum
    if (s2_v_q && (sum_sat < best_q)) begin
      best_d = sum_sat;
    end

    unique case (st_q)
      ST_LOAD: begin
        if (in_acc) begin
          // store the point
          if (in_i.is_start) begin
            if (seen_q) begin
              rep_d = 1'b1;
            end else begin
              seen_d = 1'b1;
              pt_we  = 1'b1;
            end
          end else if (count_q < JW'(MAX_POINTS - 1)) begin
            count_d  = count_q + JW'(1);
            pt_waddr = count_d;
            pt_we    = 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          // end of set: report a fault or a start-only set, or start the table walk
          if (in_i.last) begin
            priority if (ovf_d) begin
              out_load     = 1'b1;
              out_status_d = STATUS_TOO_MANY;
              count_d      = '0;
            end else if (!seen_d || rep_d) begin
              out_load     = 1'b1;
              out_status_d = STATUS_START_BAD;
              count_d      = '0;
            end else if (count_d == '0) begin
              out_load = 1'b1;
            end else begin
              mask_d  = MAX_POINTS'(3);
              j_d     = JW'(1);
              final_d = 1'b0;
              st_d    = ST_JSEL;
            end
            seen_d = 1'b0;
            rep_d  = 1'b0;
            ovf_d  = 1'b0;
          end
        end
      end

      ST_JSEL: begin
        if (mask_q[j_q]) begin
          prev_d   = mask_q ^ (MAX_POINTS'(1) << j_q);
          single_d = (prev_d == MAX_POINTS'(1));
          k_d      = single_d ? '0 : JW'(1);
          best_d   = COST_MAX;
          st_d     = ST_ISSUE;
        end else if (j_q != count_q) begin
          j_d = j_q + JW'(1);
        end else begin
          mask_d = mask_q + MAX_POINTS'(2);
          j_d    = JW'(1);
        end
      end

      ST_ISSUE: begin
        // one table and point read per predecessor k
        s1_v_d = single_q || prev_q[k_q];
        if (single_q || (k_q == count_q)) begin
          st_d = ST_WAIT1;
        end else begin
          k_d = k_q + JW'(1);
        end
      end

      ST_WAIT1: begin
        st_d = ST_WAIT2;
      end

      ST_WAIT2: begin
        st_d = ST_COMMIT;
      end

      ST_COMMIT: begin
        if (final_q) begin
          if (!out_valid_q || out_o.ready) begin
            out_load   = 1'b1;
            out_cost_d = best_q;
            count_d    = '0;
            final_d    = 1'b0;
            st_d       = ST_LOAD;
          end
        end else begin
          tbl_we = 1'b1;
          if (j_q != count_q) begin
            j_d  = j_q + JW'(1);
            st_d = ST_JSEL;
          end else if (mask_q != full) begin
            mask_d = mask_q + MAX_POINTS'(2);
            j_d    = JW'(1);
            st_d   = ST_JSEL;
          end else begin
            // closing pass: return from every k to the start
            final_d  = 1'b1;
            prev_d   = full;
            j_d      = '0;
            k_d      = JW'(1);
            single_d = 1'b0;
            best_d   = COST_MAX;
            st_d     = ST_ISSUE;
          end
        end
      end

      default: st_d = ST_LOAD;
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_acc) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_LOAD;
      count_q     <= '0;
      seen_q      <= 1'b0;
      rep_q       <= 1'b0;
      ovf_q       <= 1'b0;
      mask_q      <= '0;
      prev_q      <= '0;
      j_q         <= '0;
      k_q         <= '0;
      single_q    <= 1'b0;
      final_q     <= 1'b0;
      best_q      <= '0;
      s1_v_q      <= 1'b0;
      s1_zero_q   <= 1'b0;
      s2_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      count_q     <= count_d;
      seen_q      <= seen_d;
      rep_q       <= rep_d;
      ovf_q       <= ovf_d;
      mask_q      <= mask_d;
      prev_q      <= prev_d;
      j_q         <= j_d;
      k_q         <= k_d;
      single_q    <= single_d;
      final_q     <= final_d;
      best_q      <= best_d;
      s1_v_q      <= s1_v_d;
      s1_zero_q   <= s1_zero_d;
      s2_v_q      <= s1_v_q;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    s2_tbl_q  <= s1_zero_q ? '0 : tbl_rdata_q;
    s2_dist_q <= COST_W'(pt_dist);
    if (out_load) begin
      out_cost_q   <= out_cost_d;
      out_status_q <= out_status_d;
    end
  end

  // Point memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (pt_we) begin
      pt_row_mem[pt_waddr] <= in_i.row[CW-1:0];
      pt_col_mem[pt_waddr] <= in_i.col[CW-1:0];
    end
    pa_row_q <= pt_row_mem[k_q];
    pa_col_q <= pt_col_mem[k_q];
    pb_row_q <= pt_row_mem[j_q];
    pb_col_q <= pt_col_mem[j_q];
  end

  // Partial cost table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= best_q;
    end
    tbl_rdata_q <= tbl_mem[tbl_raddr];
  end

  // Assertions
  a_state_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(st_q))
    else $error("state register not one-hot");

  a_fault_zero_cost : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q != STATUS_OK)) |-> (out_cost_q == '0))
    else $error("faulted result carries a nonzero cost");

  a_k_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_ISSUE) |-> (k_q <= count_q))
    else $error("predecessor index beyond stored points");

  a_pipe_drained : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_COMMIT) |-> (!s1_v_q && !s2_v_q))
    else $error("table write-back before the read pipeline drained");

  a_fault_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.last && !in_i.is_start && ovf_q) |=>
      (out_valid_q && (out_status_q == STATUS_TOO_MANY)))
    else $error("overflowed set did not report too many points");

endmodule
